// ===== hw/rtl/sib_pkg.sv =====
// Shared opcodes, status codes and cell control type for the sorted insert buffer.
`timescale 1ns / 1ps

package sib_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic                      cmp_en;
        logic                      apply_en;
        logic signed [VALUE_W-1:0] cmp_value;
        logic signed [VALUE_W-1:0] ins_value;
    } sib_ctl_t;

endpackage

// ===== hw/rtl/sib_cell.sv =====
// One storage cell of the insertion chain: compares against a new word and shifts up.
`timescale 1ns / 1ps

module sib_cell
    import sib_pkg::*;
#(
    parameter int CW    = 5,
    parameter int INDEX = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sib_ctl_t                  ctl,
    input  logic [CW-1:0]             count,
    input  logic                      prev_le,
    input  logic signed [VALUE_W-1:0] prev_value,
    output logic                      le,
    output logic                      ins_here,
    output logic signed [VALUE_W-1:0] value
);

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic                      le_reg;
    logic                      le_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      cell_valid;

    assign cell_valid = (MY_INDEX < count);
    assign le_next    = cell_valid && (value_reg <= ctl.cmp_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            le_reg <= le_next;
        end
    end

    // A cell whose entry is larger than the new word either takes the new word,
    // when its lower neighbor stays put, or takes the neighbor's entry.
    always_ff @(posedge clk)
    begin
        if (ctl.apply_en && !le_reg)
        begin
            value_reg <= prev_le ? ctl.ins_value : prev_value;
        end
    end

    assign le       = le_reg;
    assign ins_here = prev_le && !le_reg;
    assign value    = value_reg;

endmodule

// ===== hw/rtl/sorted_insert_buffer.sv =====
// Top level of the sorted insert buffer: command control around a chain of sorting cells.
//
// A word is taken at a rising edge where start is high and busy is low. The
// opcode selects insert, read or clear. Every word produces exactly one result,
// shown on status, position, data_value and fill_count for one cycle while done
// is high; the receiver cannot stall, so results are never held back.
// At the accepting edge every cell compares its entry with new_value in
// parallel, and at the next edge the cells shift or load locally and the
// result is registered. done is high in the cycle after that, and busy is
// high only in between, so a new word may be started while done is high. No
// new word is taken while busy, during the compare-then-shift step of the cell
// chain. A full store drops an insert and reports it; a read at or beyond the
// fill count reports a range error.
// Reset empties the store (fill count zero) and leaves no result pending.
`timescale 1ns / 1ps

module sorted_insert_buffer
    import sib_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic signed [VALUE_W-1:0] new_value,
    input  logic [3:0]                read_index,
    output logic                      done,
    output logic [1:0]                status,
    output logic [4:0]                position,
    output logic signed [VALUE_W-1:0] data_value,
    output logic [4:0]                fill_count
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CWX   = (CW > 5) ? CW : 5;
    localparam int IW    = $clog2(CAPACITY);
    localparam int PW    = (IW > 5) ? IW : 5;
    localparam int NREAD = (CAPACITY < 16) ? CAPACITY : 16;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [1:0]                op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [3:0]                idx_reg;
    logic                      done_reg;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic [4:0]                position_reg;
    logic [PW-1:0]             position_next;
    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic [4:0]                fill_reg;
    logic [CWX-1:0]            count_wide;

    logic                      accept;
    logic                      apply_insert;
    sib_ctl_t                  ctl;
    logic [PW-1:0]             ins_pos;
    logic signed [VALUE_W-1:0] read_data;

    logic                      cell_le   [CAPACITY];
    logic                      cell_ins  [CAPACITY];
    logic signed [VALUE_W-1:0] cell_value[CAPACITY];

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_APPLY);

    assign apply_insert = (state_reg == ST_APPLY) && (op_reg == OP_INSERT)
                          && (count_reg < CAP_COUNT);

    assign ctl.cmp_en    = accept;
    assign ctl.apply_en  = apply_insert;
    assign ctl.cmp_value = new_value;
    assign ctl.ins_value = value_reg;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                sib_cell #(
                    .CW    (CW),
                    .INDEX (k)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .count      (count_reg),
                    .prev_le    (1'b1),
                    .prev_value (value_reg),
                    .le         (cell_le[k]),
                    .ins_here   (cell_ins[k]),
                    .value      (cell_value[k])
                );
            end
            else
            begin : g_rest
                sib_cell #(
                    .CW    (CW),
                    .INDEX (k)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .count      (count_reg),
                    .prev_le    (cell_le[k-1]),
                    .prev_value (cell_value[k-1]),
                    .le         (cell_le[k]),
                    .ins_here   (cell_ins[k]),
                    .value      (cell_value[k])
                );
            end
        end
    endgenerate

    // When the store is not full, exactly one cell at or below the fill count sees
    // the boundary, so its index is the insert position.
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_ins[i])
            begin
                ins_pos = ins_pos | PW'(i);
            end
        end
    end

    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < NREAD; i++)
        begin
            if (idx_reg == 4'(i))
            begin
                read_data = cell_value[i];
            end
        end
    end

    always_comb
    begin
        status_next   = STATUS_OK;
        position_next = '0;
        data_next     = '0;
        count_next    = count_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (count_reg >= CAP_COUNT)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    position_next = ins_pos;
                    data_next     = value_reg;
                    count_next    = count_reg + CW'(1);
                end
            end
            OP_READ:
            begin
                position_next = PW'(idx_reg);
                if (CWX'(idx_reg) >= CWX'(count_reg))
                begin
                    status_next = STATUS_RANGE;
                end
                else
                begin
                    data_next = read_data;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign count_wide = CWX'(count_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_APPLY);
            if (state_reg == ST_APPLY)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            value_reg <= new_value;
            idx_reg   <= read_index;
        end
        if (state_reg == ST_APPLY)
        begin
            status_reg   <= status_next;
            position_reg <= position_next[4:0];
            data_reg     <= data_next;
            fill_reg     <= count_wide[4:0];
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign position   = position_reg;
    assign data_value = data_reg;
    assign fill_count = fill_reg;

endmodule
